### rtl/nptc_pkg.sv
// Shared types, constants and a small month table for the NMEA and PPS time clock.
`timescale 1ns / 1ps
package nptc_pkg;

    // Number of pipeline stages between the input and the result register
    localparam int NST = 7;

    // Request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_PPS  = 2'd1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RMC  = 2'd1,
        KIND_ZDA  = 2'd2
    } kind_t;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;

    // Sentence names
    localparam logic [47:0] HDR_GPRMC = "$GPRMC";
    localparam logic [47:0] HDR_GNRMC = "$GNRMC";
    localparam logic [47:0] HDR_GPZDA = "$GPZDA";
    localparam logic [47:0] HDR_GNZDA = "$GNZDA";

    // Field positions
    localparam logic [3:0] FLD_HEADER   = 4'd0;
    localparam logic [3:0] FLD_TIME     = 4'd1;
    localparam logic [3:0] FLD_STATUS   = 4'd2;
    localparam logic [3:0] FLD_ZDA_DAY  = 4'd2;
    localparam logic [3:0] FLD_ZDA_MON  = 4'd3;
    localparam logic [3:0] FLD_ZDA_YEAR = 4'd4;
    localparam logic [3:0] FLD_RMC_DATE = 4'd9;
    localparam logic [3:0] CNT_MAX      = 4'd15;

    localparam logic [46:0]        NS_PER_SEC     = 47'd1000000000;
    localparam logic [13:0]        RMC_YEAR_BASE  = 14'd2000;
    localparam logic [6:0]         RESET_DAY      = 7'd1;
    localparam logic [6:0]         RESET_MON      = 7'd1;
    localparam logic [13:0]        RESET_YEAR     = 14'd1970;
    localparam logic signed [24:0] DAYS_PER_ERA   = 25'sd146097;
    localparam logic signed [25:0] DAYS_TO_EPOCH  = 26'sd719468;
    localparam logic signed [47:0] SECS_PER_DAY   = 48'sd86400;

    // Day of the March-based year on which each month starts
    function automatic logic [8:0] doy_start(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  nmea_byte;
        logic [62:0] host_ns;
        logic [33:0] pps_gps_seconds;
    } in_t;

    typedef struct packed {
        logic signed [63:0] now_ns;
        logic               locked;
        logic               time_updated;
        logic [37:0]        nmea_seconds;
    } out_t;

    typedef struct packed {
        logic               is_pps;
        logic [62:0]        host;
        logic [33:0]        secs;
        logic [46:0]        plo;
        logic [46:0]        phi;
        logic [63:0]        prod;
        logic               fin;
        logic [6:0]         hh;
        logic [6:0]         mm;
        logic [6:0]         ss;
        logic [6:0]         day;
        logic [6:0]         mon;
        logic [13:0]        yr;
        logic signed [15:0] y2;
        logic [3:0]         mp;
        logic signed [7:0]  era;
        logic [8:0]         yoe;
        logic signed [24:0] era_days;
        logic signed [19:0] doe;
        logic [18:0]        sod;
        logic signed [25:0] days;
        logic signed [47:0] t;
    } pipe_t;

endpackage

### rtl/nmea_pps_time_clock.sv
// Top level: NMEA sentence parser, PPS tracker and time pipeline.
`timescale 1ns / 1ps
//
//  channel | ports                      | payload          | accepted when
//  --------+----------------------------+------------------+-------------------
//  input   | s_valid, s_ready, s_data   | nptc_pkg::in_t   | s_valid && s_ready
//  result  | m_valid, m_ready, m_data   | nptc_pkg::out_t  | m_valid && m_ready
//
//  One item is accepted per cycle while s_ready is high; pipe stage 0 loads
//  at the accepting edge, then each later stage and the result register in
//  turn, a depth set by the date arithmetic. The line parser updates at the
//  accepting edge; clock state updates at the tail, in item order.
//  Bubbles absorb a stalled result; s_ready drops only when all stages and the
//  result register are full. Reset (aresetn low, synchronous) empties it all.
//
module nmea_pps_time_clock #(
    parameter int LINE_BYTES = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  nptc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output nptc_pkg::out_t m_data
);

    localparam int LCW = $clog2(LINE_BYTES);

    // ---------------------------------------------------------------
    // Line parser state
    // ---------------------------------------------------------------
    logic [LCW-1:0]          line_cnt_reg, line_cnt_next;
    logic [3:0]              fnum_reg, fnum_next;
    logic [3:0]              fcnt_reg, fcnt_next;
    logic [47:0]             hdr_reg, hdr_next;
    nptc_pkg::kind_t         kind_reg, kind_next;
    logic                    status_reg, status_next;
    logic [6:0]              hh_reg, hh_next, mm_reg, mm_next, ss_reg, ss_next;
    logic [6:0]              day_reg, day_next, mon_reg, mon_next;
    logic [13:0]             yr_reg, yr_next;
    logic [1:0]              tdok_reg, tdok_next;
    logic [13:0]             fval_reg, fval_next;
    logic [6:0]              pair_reg, pair_next, pa_reg, pa_next, pb_reg, pb_next;
    logic                    bad_reg, bad_next;
    logic                    stop_reg, stop_next;

    // End-of-field view of the line state
    nptc_pkg::kind_t ef_kind;
    logic [6:0]      ef_day, ef_mon;
    logic [13:0]     ef_yr;
    logic [1:0]      ef_tdok;
    logic            ef_ok;
    // Values seen by the line end
    nptc_pkg::kind_t fx_kind;
    logic [6:0]      fx_day, fx_mon;
    logic [13:0]     fx_yr;
    logic [1:0]      fx_tdok;
    logic            want;

    logic            s_acc;
    logic [7:0]      ch;
    logic            is_digit;
    logic [3:0]      dig;
    logic [6:0]      pair_new;
    logic            bad_new;
    logic            six_field;
    logic [3:0]      zda_max;

    // ---------------------------------------------------------------
    // Pipeline and tail state
    // ---------------------------------------------------------------
    nptc_pkg::pipe_t           pipe_reg [nptc_pkg::NST];
    nptc_pkg::pipe_t           calc     [nptc_pkg::NST];
    logic [nptc_pkg::NST-1:0]  pv_reg;
    logic [nptc_pkg::NST:0]    rdy;

    logic                      pps_seen_reg, pps_seen_next;
    logic [63:0]               offset_reg, offset_next;
    logic                      nmea_seen_reg, nmea_seen_next;
    logic [37:0]               nmea_time_reg, nmea_time_next;
    logic                      m_valid_reg;
    nptc_pkg::out_t            m_data_reg, out_next;
    logic                      t_upd;
    logic [63:0]               now_val;

    // Stage temporaries
    logic [6:0]         b_x;
    logic [12:0]        b_xq;
    logic [3:0]         b_q;
    logic [6:0]         b_r;
    logic [3:0]         b_m;
    logic signed [15:0] b_ys;
    logic [27:0]        c_yq;
    logic signed [15:0] d_era16, d_yoe16;
    logic signed [24:0] d_era25;
    logic [17:0]        e_y365, e_sum;
    logic [14:0]        e_y41;
    logic signed [25:0] f_ed, f_doe;
    logic signed [47:0] g_days;

    assign s_ready = rdy[0];
    assign s_acc   = s_valid && rdy[0];
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Ready chain: a stage takes a new item when empty or when it moves on
    always_comb begin
        rdy[nptc_pkg::NST] = !m_valid_reg || m_ready;
        for (int k = nptc_pkg::NST - 1; k >= 0; k--) begin
            rdy[k] = !pv_reg[k] || rdy[k+1];
        end
    end

    // ---------------------------------------------------------------
    // End of the current field: header match and the ZDA date fields
    // ---------------------------------------------------------------
    always_comb begin
        ef_kind = kind_reg;
        ef_day  = day_reg;
        ef_mon  = mon_reg;
        ef_yr   = yr_reg;
        ef_tdok = tdok_reg;
        ef_ok   = !bad_reg && (fcnt_reg != 4'd0);
        if (fnum_reg == nptc_pkg::FLD_HEADER) begin
            if (fcnt_reg == 4'd6) begin
                if (hdr_reg == nptc_pkg::HDR_GPRMC || hdr_reg == nptc_pkg::HDR_GNRMC) begin
                    ef_kind = nptc_pkg::KIND_RMC;
                end else if (hdr_reg == nptc_pkg::HDR_GPZDA ||
                             hdr_reg == nptc_pkg::HDR_GNZDA) begin
                    ef_kind = nptc_pkg::KIND_ZDA;
                end
            end
        end else if (kind_reg == nptc_pkg::KIND_ZDA) begin
            case (fnum_reg)
                nptc_pkg::FLD_ZDA_DAY: begin
                    ef_day  = fval_reg[6:0];
                    ef_tdok = ef_ok ? (tdok_reg | 2'b10) : (tdok_reg & 2'b01);
                end
                nptc_pkg::FLD_ZDA_MON: begin
                    ef_mon = fval_reg[6:0];
                    if (!ef_ok) begin
                        ef_tdok = tdok_reg & 2'b01;
                    end
                end
                nptc_pkg::FLD_ZDA_YEAR: begin
                    ef_yr = fval_reg;
                    if (!ef_ok) begin
                        ef_tdok = tdok_reg & 2'b01;
                    end
                end
                default: ;
            endcase
        end

        // A stopped line has already closed its last field
        fx_kind = stop_reg ? kind_reg : ef_kind;
        fx_day  = stop_reg ? day_reg  : ef_day;
        fx_mon  = stop_reg ? mon_reg  : ef_mon;
        fx_yr   = stop_reg ? yr_reg   : ef_yr;
        fx_tdok = stop_reg ? tdok_reg : ef_tdok;
        case (fx_kind)
            nptc_pkg::KIND_RMC: want = status_reg && (fx_tdok == 2'b11);
            nptc_pkg::KIND_ZDA: want = (fx_tdok == 2'b11) &&
                                       (fnum_reg >= nptc_pkg::FLD_ZDA_YEAR);
            default:            want = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Byte handling
    // ---------------------------------------------------------------
    always_comb begin
        ch       = s_data.nmea_byte;
        is_digit = (ch >= nptc_pkg::CH_ZERO) && (ch <= nptc_pkg::CH_NINE);
        dig      = 4'(ch - nptc_pkg::CH_ZERO);
        pair_new = fcnt_reg[0] ? 7'(pair_reg * 7'd10 + 7'(dig)) : {3'b000, dig};
        bad_new  = bad_reg || !is_digit;
        six_field = (kind_reg != nptc_pkg::KIND_NONE) &&
                    ((fnum_reg == nptc_pkg::FLD_TIME) ||
                     (kind_reg == nptc_pkg::KIND_RMC && fnum_reg == nptc_pkg::FLD_RMC_DATE));
        zda_max  = (fnum_reg == nptc_pkg::FLD_ZDA_YEAR) ? 4'd4 : 4'd2;

        line_cnt_next = line_cnt_reg;
        fnum_next     = fnum_reg;
        fcnt_next     = fcnt_reg;
        hdr_next      = hdr_reg;
        kind_next     = kind_reg;
        status_next   = status_reg;
        hh_next       = hh_reg;
        mm_next       = mm_reg;
        ss_next       = ss_reg;
        day_next      = day_reg;
        mon_next      = mon_reg;
        yr_next       = yr_reg;
        tdok_next     = tdok_reg;
        fval_next     = fval_reg;
        pair_next     = pair_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        bad_next      = bad_reg;
        stop_next     = stop_reg;

        if (s_acc && s_data.req_type == nptc_pkg::REQ_BYTE) begin
            if (ch == nptc_pkg::CH_CR || ch == nptc_pkg::CH_LF) begin
                // Start a fresh line
                line_cnt_next = '0;
                fnum_next     = '0;
                fcnt_next     = '0;
                hdr_next      = '0;
                kind_next     = nptc_pkg::KIND_NONE;
                status_next   = 1'b0;
                hh_next       = '0;
                mm_next       = '0;
                ss_next       = '0;
                day_next      = nptc_pkg::RESET_DAY;
                mon_next      = nptc_pkg::RESET_MON;
                yr_next       = nptc_pkg::RESET_YEAR;
                tdok_next     = '0;
                fval_next     = '0;
                bad_next      = 1'b0;
                stop_next     = 1'b0;
            end else if (line_cnt_reg < LCW'(LINE_BYTES - 1)) begin
                line_cnt_next = line_cnt_reg + 1'b1;
                if (!stop_reg) begin
                    if (ch == nptc_pkg::CH_STAR || ch == nptc_pkg::CH_NUL) begin
                        kind_next = ef_kind;
                        day_next  = ef_day;
                        mon_next  = ef_mon;
                        yr_next   = ef_yr;
                        tdok_next = ef_tdok;
                        stop_next = 1'b1;
                    end else if (ch == nptc_pkg::CH_COMMA) begin
                        kind_next = ef_kind;
                        day_next  = ef_day;
                        mon_next  = ef_mon;
                        yr_next   = ef_yr;
                        tdok_next = ef_tdok;
                        fnum_next = (fnum_reg < nptc_pkg::CNT_MAX) ? fnum_reg + 1'b1
                                                                   : nptc_pkg::CNT_MAX;
                        fcnt_next = '0;
                        fval_next = '0;
                        bad_next  = 1'b0;
                    end else begin
                        if (fnum_reg == nptc_pkg::FLD_HEADER) begin
                            if (fcnt_reg < 4'd6) begin
                                hdr_next = {hdr_reg[39:0], ch};
                            end
                        end else if (six_field) begin
                            if (fcnt_reg < 4'd6) begin
                                bad_next = bad_new;
                                if (is_digit) begin
                                    pair_next = pair_new;
                                end
                                if (fcnt_reg == 4'd1) begin
                                    pa_next = pair_new;
                                end
                                if (fcnt_reg == 4'd3) begin
                                    pb_next = pair_new;
                                end
                                if (fcnt_reg == 4'd5 && !bad_new) begin
                                    if (fnum_reg == nptc_pkg::FLD_TIME) begin
                                        hh_next   = pa_reg;
                                        mm_next   = pb_reg;
                                        ss_next   = pair_new;
                                        tdok_next = tdok_reg | 2'b01;
                                    end else begin
                                        day_next  = pa_reg;
                                        mon_next  = pb_reg;
                                        yr_next   = nptc_pkg::RMC_YEAR_BASE + 14'(pair_new);
                                        tdok_next = tdok_reg | 2'b10;
                                    end
                                end
                            end
                        end else if (kind_reg == nptc_pkg::KIND_RMC &&
                                     fnum_reg == nptc_pkg::FLD_STATUS) begin
                            if (fcnt_reg == 4'd0 && ch == nptc_pkg::CH_A) begin
                                status_next = 1'b1;
                            end
                        end else if (kind_reg == nptc_pkg::KIND_ZDA &&
                                     fnum_reg >= nptc_pkg::FLD_ZDA_DAY &&
                                     fnum_reg <= nptc_pkg::FLD_ZDA_YEAR) begin
                            if (fcnt_reg >= zda_max || !is_digit) begin
                                bad_next = 1'b1;
                            end else begin
                                fval_next = 14'(fval_reg * 14'd10 + 14'(dig));
                            end
                        end
                        fcnt_next = (fcnt_reg < nptc_pkg::CNT_MAX) ? fcnt_reg + 1'b1
                                                                   : nptc_pkg::CNT_MAX;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Pipeline stage logic
    // ---------------------------------------------------------------
    always_comb begin
        // Entry: capture the item and, at a line end, the decoded fields
        calc[0]        = '0;
        calc[0].is_pps = (s_data.req_type == nptc_pkg::REQ_PPS);
        calc[0].host   = s_data.host_ns;
        calc[0].secs   = s_data.pps_gps_seconds;
        calc[0].fin    = (s_data.req_type == nptc_pkg::REQ_BYTE) && want &&
                         (ch == nptc_pkg::CH_CR || ch == nptc_pkg::CH_LF);
        calc[0].hh     = hh_reg;
        calc[0].mm     = mm_reg;
        calc[0].ss     = ss_reg;
        calc[0].day    = fx_day;
        calc[0].mon    = fx_mon;
        calc[0].yr     = fx_yr;

        // Split the PPS product; fold the month into the year
        calc[1]     = pipe_reg[0];
        calc[1].plo = 47'(pipe_reg[0].secs[16:0]) * nptc_pkg::NS_PER_SEC;
        calc[1].phi = 47'(pipe_reg[0].secs[33:17]) * nptc_pkg::NS_PER_SEC;
        b_x  = pipe_reg[0].mon - 7'd1;
        b_xq = 13'(b_x) * 13'd43;          // divide by 12 for values below 128
        b_q  = b_xq[12:9];
        b_r  = b_x - 7'(b_q) * 7'd12;
        if (pipe_reg[0].mon == 7'd0) begin
            b_m  = 4'd12;
            b_ys = $signed({2'b00, pipe_reg[0].yr}) - 16'sd1;
        end else begin
            b_m  = b_r[3:0] + 4'd1;
            b_ys = $signed({2'b00, pipe_reg[0].yr}) + $signed({12'd0, b_q});
        end
        calc[1].y2 = (b_m <= 4'd2) ? b_ys - 16'sd1 : b_ys;
        calc[1].mp = (b_m > 4'd2) ? b_m - 4'd3 : b_m + 4'd9;

        // Join the PPS product; era = floor(y / 400)
        calc[2]      = pipe_reg[1];
        calc[2].prod = 64'(pipe_reg[1].plo) + (64'(pipe_reg[1].phi) << 17);
        c_yq = 28'(pipe_reg[1].y2[14:0]) * 28'd5243;
        calc[2].era = pipe_reg[1].y2[15] ? -8'sd1 : $signed({1'b0, c_yq[27:21]});

        // Year of era and days of whole eras
        calc[3]          = pipe_reg[2];
        d_era16          = 16'(pipe_reg[2].era);
        d_era25          = 25'(pipe_reg[2].era);
        d_yoe16          = pipe_reg[2].y2 - d_era16 * 16'sd400;
        calc[3].yoe      = d_yoe16[8:0];
        calc[3].era_days = d_era25 * nptc_pkg::DAYS_PER_ERA;

        // Day of era and second of day
        calc[4] = pipe_reg[3];
        e_y365  = 18'(pipe_reg[3].yoe) * 18'd365;
        e_y41   = 15'(pipe_reg[3].yoe) * 15'd41;   // divide by 100 below 400
        e_sum   = e_y365 + 18'(pipe_reg[3].yoe[8:2]) - 18'(e_y41[14:12]) +
                  18'(nptc_pkg::doy_start(pipe_reg[3].mp)) + 18'(pipe_reg[3].day);
        calc[4].doe = $signed({2'b00, e_sum}) - 20'sd1;
        calc[4].sod = 19'(pipe_reg[3].hh) * 19'd3600 + 19'(pipe_reg[3].mm) * 19'd60 +
                      19'(pipe_reg[3].ss);

        // Days since the Unix epoch
        calc[5]      = pipe_reg[4];
        f_ed         = 26'(pipe_reg[4].era_days);
        f_doe        = 26'(pipe_reg[4].doe);
        calc[5].days = f_ed + f_doe - nptc_pkg::DAYS_TO_EPOCH;

        // Seconds since the Unix epoch
        calc[6]   = pipe_reg[5];
        g_days    = 48'(pipe_reg[5].days);
        calc[6].t = g_days * nptc_pkg::SECS_PER_DAY + $signed({29'd0, pipe_reg[5].sod});
    end

    // ---------------------------------------------------------------
    // Tail: clock state and the result
    // ---------------------------------------------------------------
    always_comb begin
        t_upd          = pipe_reg[nptc_pkg::NST-1].fin && !pipe_reg[nptc_pkg::NST-1].t[47];
        pps_seen_next  = pps_seen_reg | pipe_reg[nptc_pkg::NST-1].is_pps;
        offset_next    = pipe_reg[nptc_pkg::NST-1].is_pps ?
                         pipe_reg[nptc_pkg::NST-1].prod - {1'b0, pipe_reg[nptc_pkg::NST-1].host}
                         : offset_reg;
        nmea_seen_next = nmea_seen_reg | t_upd;
        nmea_time_next = t_upd ? pipe_reg[nptc_pkg::NST-1].t[37:0] : nmea_time_reg;
        if (pipe_reg[nptc_pkg::NST-1].is_pps) begin
            now_val = pipe_reg[nptc_pkg::NST-1].prod;
        end else if (pps_seen_reg) begin
            now_val = offset_reg + {1'b0, pipe_reg[nptc_pkg::NST-1].host};
        end else begin
            now_val = {1'b0, pipe_reg[nptc_pkg::NST-1].host};
        end
        out_next.now_ns       = $signed(now_val);
        out_next.locked       = pps_seen_next && nmea_seen_next;
        out_next.time_updated = t_upd;
        out_next.nmea_seconds = nmea_time_next;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg        <= '0;
            m_valid_reg   <= 1'b0;
            pps_seen_reg  <= 1'b0;
            offset_reg    <= '0;
            nmea_seen_reg <= 1'b0;
            nmea_time_reg <= '0;
            line_cnt_reg  <= '0;
            fnum_reg      <= '0;
            fcnt_reg      <= '0;
            hdr_reg       <= '0;
            kind_reg      <= nptc_pkg::KIND_NONE;
            status_reg    <= 1'b0;
            hh_reg        <= '0;
            mm_reg        <= '0;
            ss_reg        <= '0;
            day_reg       <= nptc_pkg::RESET_DAY;
            mon_reg       <= nptc_pkg::RESET_MON;
            yr_reg        <= nptc_pkg::RESET_YEAR;
            tdok_reg      <= '0;
            fval_reg      <= '0;
            pair_reg      <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
            bad_reg       <= 1'b0;
            stop_reg      <= 1'b0;
        end else begin
            if (rdy[0]) begin
                pv_reg[0] <= s_valid;
            end
            for (int k = 1; k < nptc_pkg::NST; k++) begin
                if (rdy[k]) begin
                    pv_reg[k] <= pv_reg[k-1];
                end
            end
            if (rdy[nptc_pkg::NST]) begin
                m_valid_reg <= pv_reg[nptc_pkg::NST-1];
                if (pv_reg[nptc_pkg::NST-1]) begin
                    pps_seen_reg  <= pps_seen_next;
                    offset_reg    <= offset_next;
                    nmea_seen_reg <= nmea_seen_next;
                    nmea_time_reg <= nmea_time_next;
                end
            end
            line_cnt_reg <= line_cnt_next;
            fnum_reg     <= fnum_next;
            fcnt_reg     <= fcnt_next;
            hdr_reg      <= hdr_next;
            kind_reg     <= kind_next;
            status_reg   <= status_next;
            hh_reg       <= hh_next;
            mm_reg       <= mm_next;
            ss_reg       <= ss_next;
            day_reg      <= day_next;
            mon_reg      <= mon_next;
            yr_reg       <= yr_next;
            tdok_reg     <= tdok_next;
            fval_reg     <= fval_next;
            pair_reg     <= pair_next;
            pa_reg       <= pa_next;
            pb_reg       <= pb_next;
            bad_reg      <= bad_next;
            stop_reg     <= stop_next;
        end
    end

    // Payload registers: load when the stage moves on
    always_ff @(posedge aclk) begin
        for (int k = 0; k < nptc_pkg::NST; k++) begin
            if (rdy[k]) begin
                pipe_reg[k] <= calc[k];
            end
        end
        if (rdy[nptc_pkg::NST] && pv_reg[nptc_pkg::NST-1]) begin
            m_data_reg <= out_next;
        end
    end

endmodule

### rtl/nptc_checker.sv
// Port checker for the NMEA and PPS time clock, bound to the top level.
`timescale 1ns / 1ps
module nptc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input nptc_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input nptc_pkg::out_t m_data
);

    logic lock_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_data.locked) begin
            lock_seen_reg <= 1'b1;
        end
    end

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Input is never refused while the result side can move
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input refused with result side free");

    // Lock is sticky across results
    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && lock_seen_reg |-> m_data.locked)
        else $error("lock dropped");

endmodule

bind nmea_pps_time_clock nptc_checker u_nptc_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for the NMEA and PPS time clock.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int LINE_LEN = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    nptc_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    nptc_pkg::out_t m_data;

    nmea_pps_time_clock #(.LINE_BYTES(LINE_LEN)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    nptc_pkg::in_t  pending_items[$];
    nptc_pkg::out_t expected_times[$];
    int   phase = 0;
    int   send_idle = 17;
    int   recv_idle = 71;
    int   errors = 0;
    int   cycles = 0;
    logic [62:0] stamp_ns = '0;

    // Shadow state of the clock and the line parser
    logic        pps_seen, nmea_seen;
    logic [63:0] pps_host, pps_gps;
    logic [37:0] nmea_secs;
    int unsigned line_len, fld_num, fld_chars, fld_value;
    logic [47:0] header;
    nptc_pkg::kind_t kind;
    logic        status_a, fld_bad, data_stopped;
    logic [20:0] tod;
    logic [27:0] ymd;
    logic [1:0]  have;

    function automatic void clear_line();
        line_len = 0; fld_num = 0; fld_chars = 0; fld_value = 0;
        header = '0; kind = nptc_pkg::KIND_NONE; status_a = 1'b0;
        tod = '0;
        ymd = {nptc_pkg::RESET_YEAR, nptc_pkg::RESET_MON, nptc_pkg::RESET_DAY};
        have = 2'b00;
        fld_bad = 1'b0; data_stopped = 1'b0;
    endfunction

    function automatic void clock_reset();
        pps_seen = 1'b0; nmea_seen = 1'b0;
        pps_host = '0; pps_gps = '0; nmea_secs = '0;
        clear_line();
    endfunction

    // Close the current field: header match or a ZDA date part
    function automatic void close_field();
        logic ok;
        if (fld_num == 0) begin
            if (fld_chars == 6) begin
                if (header == nptc_pkg::HDR_GPRMC || header == nptc_pkg::HDR_GNRMC)
                    kind = nptc_pkg::KIND_RMC;
                else if (header == nptc_pkg::HDR_GPZDA || header == nptc_pkg::HDR_GNZDA)
                    kind = nptc_pkg::KIND_ZDA;
            end
            return;
        end
        if (kind != nptc_pkg::KIND_ZDA || fld_num < 2 || fld_num > 4) return;
        ok = !fld_bad && fld_chars >= 1;
        if (fld_num == 2) begin
            ymd[6:0] = fld_value[6:0];
            have[1] = ok;
        end else if (fld_num == 3) begin
            ymd[13:7] = fld_value[6:0];
            if (!ok) have[1] = 1'b0;
        end else begin
            ymd[27:14] = fld_value[13:0];
            if (!ok) have[1] = 1'b0;
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        int unsigned p, a, b, e, maxlen;
        logic digit;
        p = fld_chars;
        digit = c >= nptc_pkg::CH_ZERO && c <= nptc_pkg::CH_NINE;
        if (fld_num == 0) begin
            if (p < 6) header = {header[39:0], c};
        end else if (kind != nptc_pkg::KIND_NONE && (fld_num == 1 ||
                     (kind == nptc_pkg::KIND_RMC && fld_num == 9))) begin
            if (p < 6) begin
                if (digit) fld_value = fld_value * 10 + 32'(c - nptc_pkg::CH_ZERO);
                else fld_bad = 1'b1;
                if (p == 5 && !fld_bad) begin
                    a = fld_value / 10000; b = (fld_value / 100) % 100; e = fld_value % 100;
                    if (fld_num == 1) begin
                        tod = {a[6:0], b[6:0], e[6:0]};
                        have[0] = 1'b1;
                    end else begin
                        ymd = {14'(2000 + e), b[6:0], a[6:0]};
                        have[1] = 1'b1;
                    end
                end
            end
        end else if (kind == nptc_pkg::KIND_RMC && fld_num == 2) begin
            if (p == 0 && c == nptc_pkg::CH_A) status_a = 1'b1;
        end else if (kind == nptc_pkg::KIND_ZDA && fld_num >= 2 && fld_num <= 4) begin
            maxlen = (fld_num == 4) ? 4 : 2;
            if (p >= maxlen || !digit) fld_bad = 1'b1;
            else fld_value = fld_value * 10 + 32'(c - nptc_pkg::CH_ZERO);
        end
        fld_chars = (p < 32'(nptc_pkg::CNT_MAX)) ? p + 1 : 32'(nptc_pkg::CNT_MAX);
    endfunction

    function automatic longint civil_days(longint y, longint m, longint d);
        longint era, yoe, doy, doe;
        if (m <= 2) y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    // Convert a completed line; returns 1 when a time was stored
    function automatic logic finish_line();
        longint mon0, yr, t;
        logic wanted;
        if (!data_stopped) close_field();
        if (kind == nptc_pkg::KIND_RMC) wanted = status_a && have == 2'b11;
        else if (kind == nptc_pkg::KIND_ZDA) wanted = have == 2'b11 && fld_num >= 4;
        else wanted = 1'b0;
        if (!wanted) return 1'b0;
        mon0 = longint'(ymd[13:7]) - 1;
        yr = longint'(ymd[27:14]);
        if (mon0 < 0) begin
            yr = yr - 1; mon0 = mon0 + 12;
        end else begin
            yr = yr + mon0 / 12; mon0 = mon0 % 12;
        end
        t = (civil_days(yr, mon0 + 1, 1) + longint'(ymd[6:0]) - 1) * 86400
            + longint'(tod[20:14]) * 3600 + longint'(tod[13:7]) * 60 + longint'(tod[6:0]);
        if (t < 0) return 1'b0;
        nmea_secs = t[37:0];
        nmea_seen = 1'b1;
        return 1'b1;
    endfunction

    function automatic nptc_pkg::out_t clock_step(nptc_pkg::in_t it);
        nptc_pkg::out_t r;
        logic upd;
        logic [7:0] c;
        upd = 1'b0;
        c = it.nmea_byte;
        if (it.req_type == nptc_pkg::REQ_BYTE) begin
            if (c == nptc_pkg::CH_CR || c == nptc_pkg::CH_LF) begin
                upd = finish_line();
                clear_line();
            end else if (line_len < LINE_LEN - 1) begin
                line_len++;
                if (!data_stopped) begin
                    if (c == nptc_pkg::CH_STAR || c == nptc_pkg::CH_NUL) begin
                        close_field();
                        data_stopped = 1'b1;
                    end else if (c == nptc_pkg::CH_COMMA) begin
                        close_field();
                        fld_num = (fld_num < 32'(nptc_pkg::CNT_MAX)) ? fld_num + 1
                                                                     : 32'(nptc_pkg::CNT_MAX);
                        fld_chars = 0; fld_value = 0; fld_bad = 1'b0;
                    end else begin
                        take_char(c);
                    end
                end
            end
        end else if (it.req_type == nptc_pkg::REQ_PPS) begin
            pps_host = {1'b0, it.host_ns};
            pps_gps = 64'(it.pps_gps_seconds) * 64'(nptc_pkg::NS_PER_SEC);
            pps_seen = 1'b1;
        end
        r.now_ns = pps_seen ? pps_gps + ({1'b0, it.host_ns} - pps_host) : {1'b0, it.host_ns};
        r.locked = pps_seen && nmea_seen;
        r.time_updated = upd;
        r.nmea_seconds = nmea_secs;
        return r;
    endfunction

    // Stimulus helpers
    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic logic [33:0] rand34();
        return 34'({$urandom, $urandom});
    endfunction

    task automatic put_item(logic [1:0] rq, logic [7:0] ch, logic [33:0] secs);
        nptc_pkg::in_t it;
        if ($urandom_range(49) == 0) stamp_ns = rand63();
        else stamp_ns = stamp_ns + 63'($urandom_range(1, 3000000));
        it.req_type = rq;
        it.nmea_byte = ch;
        it.host_ns = stamp_ns;
        it.pps_gps_seconds = secs;
        pending_items.push_back(it);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_item(nptc_pkg::REQ_BYTE, s[i], rand34());
    endtask

    function automatic string rmc_line(int hh, int mm, int ss, int dd, int mo, int yy, byte st);
        return $sformatf("$G%sRMC,%02d%02d%02d.00,%c,4807.038,N,01131.000,E,022.4,084.4,%02d%02d%02d,003.1,W*6A\r\n",
                         $urandom_range(1) ? "P" : "N", hh, mm, ss, st, dd, mo, yy);
    endfunction

    function automatic string zda_line(int hh, int mm, int ss, int dd, int mo, int yr);
        return $sformatf("$G%sZDA,%02d%02d%02d.00,%0d,%0d,%0d,00,00*4F\r\n",
                         $urandom_range(1) ? "P" : "N", hh, mm, ss, dd, mo, yr);
    endfunction

    // Corrupt one character now and then, so broken lines are mixed in
    function automatic string mangle(string s);
        if ($urandom_range(4) == 0) s[$urandom_range(s.len() - 3)] = byte'($urandom_range(255));
        return s;
    endfunction

    task automatic put_random(int count);
        int start, pick;
        start = pending_items.size();
        while (pending_items.size() - start < count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                put_text(mangle(rmc_line($urandom_range(99), $urandom_range(99), $urandom_range(99),
                                         $urandom_range(99), $urandom_range(99), $urandom_range(99),
                                         $urandom_range(5) ? "A" : "V")));
            end else if (pick < 65) begin
                put_text(mangle(zda_line($urandom_range(99), $urandom_range(99), $urandom_range(99),
                                         $urandom_range(99), $urandom_range(99),
                                         $urandom_range(3) ? $urandom_range(1960, 2200)
                                                           : $urandom_range(9999))));
            end else if (pick < 78) begin
                put_item(nptc_pkg::REQ_PPS, byte'($urandom), rand34());
            end else if (pick < 88) begin
                put_item($urandom_range(1) ? REQ_QUERY : REQ_SPARE, byte'($urandom), rand34());
            end else begin
                repeat ($urandom_range(1, 8)) put_item(nptc_pkg::REQ_BYTE, byte'($urandom), rand34());
            end
        end
    endtask

    // Driver: offer the next pending item, holding it until it is taken
    always @(posedge aclk) begin : drive
        nptc_pkg::in_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                it = pending_items.pop_front();
                expected_times.push_back(clock_step(it));
                s_data <= it;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result item and pace m_ready
    int hold_left = 0;
    int seen_phase = 0;
    always @(posedge aclk) begin : watch
        nptc_pkg::out_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_times.size() == 0) begin
                    $error("result item with nothing expected");
                    errors++;
                end else begin
                    e = expected_times.pop_front();
                    if (m_data.now_ns !== e.now_ns) begin
                        $error("now_ns: expected %0d, got %0d", e.now_ns, m_data.now_ns);
                        errors++;
                    end
                    if (m_data.locked !== e.locked) begin
                        $error("locked: expected %0b, got %0b", e.locked, m_data.locked);
                        errors++;
                    end
                    if (m_data.time_updated !== e.time_updated) begin
                        $error("time_updated: expected %0b, got %0b",
                               e.time_updated, m_data.time_updated);
                        errors++;
                    end
                    if (m_data.nmea_seconds !== e.nmea_seconds) begin
                        $error("nmea_seconds: expected %0d, got %0d",
                               e.nmea_seconds, m_data.nmea_seconds);
                        errors++;
                    end
                end
            end
            // Hold off for a long stretch when the final phase begins
            if (phase != seen_phase) begin
                seen_phase <= phase;
                hold_left <= (phase == 2) ? HOLD_CYCLES : 0;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(99) >= recv_idle;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || expected_times.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    initial begin
        clock_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, every request and the special lines
        put_item(REQ_QUERY, 8'hFF, 34'h3_FFFF_FFFF);
        put_item(REQ_SPARE, 8'h00, '0);
        pending_items[$].host_ns = '1;
        put_item(nptc_pkg::REQ_PPS, 8'h00, 34'h3_FFFF_FFFF);
        pending_items[$].host_ns = '0;
        put_item(REQ_QUERY, 8'h00, '0);
        pending_items[$].host_ns = '1;
        put_text(rmc_line(12, 34, 56, 15, 6, 24, "A"));
        put_text(rmc_line(1, 2, 3, 4, 5, 6, "V"));
        put_text(zda_line(23, 59, 60, 0, 0, 1970));
        put_text(zda_line(0, 0, 0, 31, 12, 1969));
        put_text("$GPZDA,000000,1x,1,2000,00,00\n\n");
        put_text("$GPRMC,1234\r\n");
        put_text("$GPRMC,120000,A,,,,,,,010100");
        put_item(nptc_pkg::REQ_BYTE, nptc_pkg::CH_NUL, '0);
        put_text(",junk\r");
        put_text("$GPXYZ,120000*00\n");
        repeat (300) put_item(nptc_pkg::REQ_BYTE, "9", '0);
        put_text("\r\n");
        put_item(nptc_pkg::REQ_PPS, 8'h00, 34'd1700000000);
        put_random(330);
        drain();

        phase = 1; send_idle = 71; recv_idle = 17;
        put_random(350);
        drain();

        phase = 2; send_idle = 0; recv_idle = 0;
        put_random(350);
        drain();

        repeat (nptc_pkg::NST + 20) @(posedge aclk);
        if (errors == 0 && expected_times.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
